[rtl/ppmenc_pkg.sv]
// Shared types, constants and digit helpers for the PPM pixel body encoder.
// No dependencies.
package ppmenc_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int DIM_W          = 16;
	localparam int CFG_IDX_W      = 8;
	localparam int CFG_DATA_W     = 16;
	localparam int PIX_W          = 8;
	localparam int MAX_BYTES      = 14;
	localparam int CNT_W          = 4;
	localparam int STREAM_W       = MAX_BYTES * 8;

	localparam logic signed [7:0] BUDGET_FULL    = 8'sd70;
	localparam logic signed [7:0] BUDGET_NEWLINE = 8'sd69;

	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_SPACE = 8'h20;
	localparam logic [7:0] ASCII_LF    = 8'h0A;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OUTPUT_MODE  = 8'd0,
		CFG_IMAGE_WIDTH  = 8'd1,
		CFG_IMAGE_HEIGHT = 8'd2
	} cfg_reg_t;

	typedef enum logic {
		MODE_BINARY = 1'b0,
		MODE_ASCII  = 1'b1
	} out_mode_t;

	// Decimal split of one component; len is the digit count (1..3).
	typedef struct packed {
		logic [3:0] hund;
		logic [3:0] tens;
		logic [3:0] ones;
		logic [1:0] len;
	} digits_t;

	function automatic digits_t to_digits(input logic [7:0] v);
		digits_t    d;
		logic [6:0] rem;
		logic [14:0] prod;
		logic [6:0] tens_x10;
		begin
			if (v >= 8'd200) begin
				d.hund = 4'd2;
				rem    = 7'(v - 8'd200);
			end else if (v >= 8'd100) begin
				d.hund = 4'd1;
				rem    = 7'(v - 8'd100);
			end else begin
				d.hund = 4'd0;
				rem    = v[6:0];
			end
			// rem < 100: rem*205 >> 11 is exact division by ten here
			prod     = 15'(rem) * 15'd205;
			d.tens   = 4'(prod >> 11);
			tens_x10 = 7'(d.tens) * 7'd10;
			d.ones   = 4'(rem - tens_x10);
			if (d.hund != 4'd0)      d.len = 2'd3;
			else if (d.tens != 4'd0) d.len = 2'd2;
			else                     d.len = 2'd1;
			return d;
		end
	endfunction

	// Text of one component with its trailing space, first byte in the low bits.
	function automatic logic [31:0] digit_chunk(input digits_t d);
		logic [7:0] ch_h;
		logic [7:0] ch_t;
		logic [7:0] ch_o;
		begin
			ch_h = ASCII_ZERO + 8'(d.hund);
			ch_t = ASCII_ZERO + 8'(d.tens);
			ch_o = ASCII_ZERO + 8'(d.ones);
			unique case (d.len)
				2'd3:    return {ASCII_SPACE, ch_o, ch_t, ch_h};
				2'd2:    return {8'h00, ASCII_SPACE, ch_o, ch_t};
				default: return {16'h0000, ASCII_SPACE, ch_o};
			endcase
		end
	endfunction

endpackage

[rtl/ppmenc_pix_if.sv]
// Pixel input channel: valid/ready with one RGB pixel per transfer.
// Depends on ppmenc_pkg.
interface ppmenc_pix_if import ppmenc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] red;
	logic [PIX_W-1:0] green;
	logic [PIX_W-1:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink   (input valid, red, green, blue, output ready);
endinterface

[rtl/ppmenc_byte_if.sv]
// Byte output channel: valid/ready with one body byte and its flags per transfer.
// Depends on ppmenc_pkg.
interface ppmenc_byte_if import ppmenc_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_pixel;
	logic       end_of_image;

	modport source (output valid, out_byte, last_of_pixel, end_of_image, input ready);
	modport sink   (input valid, out_byte, last_of_pixel, end_of_image, output ready);
endinterface

[rtl/ppmenc_cfg_if.sv]
// Configuration write channel: valid/ready with register index and write data.
// Depends on ppmenc_pkg.
interface ppmenc_cfg_if import ppmenc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[rtl/ppm_pixel_body_encoder.sv]
// PPM pixel body encoder: turns raster-order RGB pixels into P6 or P3 body bytes.
// Depends on ppmenc_pkg and the ppmenc_pix_if, ppmenc_byte_if, ppmenc_cfg_if interfaces.
//
// Usage:
//   cfg      : register writes (0 output_mode, 1 image_width, 2 image_height).
//              Always ready; unknown indexes are dropped. Write only while idle.
//   pix_in   : one pixel per transfer, in raster order.
//   byte_out : one body byte per transfer, with last_of_pixel on the final
//              byte of a pixel and end_of_image on the final byte of the image.
// Pipeline: pix_in -> s1 (pixel + row/newline decisions) -> s2 (expanded
//   byte string, shifted out one byte per cycle while byte_out accepts) ->
//   output register. A pixel is registered in s1, expanded into s2, and its
//   first byte is then loaded into the output register that drives byte_out.
// Throughput: one output byte per cycle while byte_out.ready is high; a pixel
//   gives 3 bytes in binary mode and 6 to 14 bytes in ASCII mode, so the byte
//   output port sets the rate. The next pixel is taken while the current one drains.
// Reset: counters clear, budget returns to 70, registers go to binary mode
//   and a 1x1 image; all stages empty.
// Stall: when byte_out.ready is low the output register holds, s2 and s1 fill
//   up, and then pix_in.ready drops. Nothing is lost or repeated.
module ppm_pixel_body_encoder import ppmenc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	ppmenc_cfg_if.sink    cfg,
	ppmenc_pix_if.sink    pix_in,
	ppmenc_byte_if.source byte_out
);

	// compare width covers both the counter and the 16-bit bounds
	localparam int CMP_W = ((COORD_BITS > DIM_W) ? COORD_BITS : DIM_W) + 1;

	// configuration registers
	out_mode_t        mode_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;

	// position and line state, advanced at pixel acceptance
	logic [COORD_BITS-1:0] column_q;
	logic [COORD_BITS-1:0] row_q;
	logic signed [7:0]     budget_q;

	// stage 1: accepted pixel and its decisions
	logic             s1_v;
	logic [PIX_W-1:0] red_s1, green_s1, blue_s1;
	logic             ascii_s1;
	logic             nl_s1;
	logic             row_end_s1;
	logic             img_end_s1;

	// stage 2: byte string being shifted out, byte 0 in the low bits
	logic [STREAM_W-1:0] bytes_s2;
	logic [CNT_W-1:0]    cnt_s2;
	logic                img_end_s2;

	// output register
	logic       out_v_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       out_eoi_q;

	logic accept;
	logic s1_move;
	logic out_load;

	// acceptance-time decisions
	logic [CMP_W-1:0]  col_inc;
	logic [CMP_W-1:0]  row_inc;
	logic              row_end;
	logic              img_end;
	logic              nl_needed;
	digits_t           dg_in [3];
	logic [3:0]        cost;
	logic signed [7:0] budget_base;
	logic signed [7:0] budget_next;

	// expansion of stage 1 into a byte string
	digits_t             dg_s1 [3];
	logic [STREAM_W-1:0] stream;
	logic [CNT_W-1:0]    pos;

	//--------------------------------------------------------------------
	// Configuration port
	//--------------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_BINARY;
			width_q  <= DIM_W'(1);
			height_q <= DIM_W'(1);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_OUTPUT_MODE:  mode_q   <= out_mode_t'(cfg.data[0]);
				CFG_IMAGE_WIDTH:  width_q  <= cfg.data[DIM_W-1:0];
				CFG_IMAGE_HEIGHT: height_q <= cfg.data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	//--------------------------------------------------------------------
	// Handshake control
	//--------------------------------------------------------------------
	assign out_load      = (cnt_s2 != '0) && (!out_v_q || byte_out.ready);
	// s2 frees up when empty or when its last byte moves out this cycle
	assign s1_move       = s1_v && ((cnt_s2 == '0) ||
	                                ((cnt_s2 == CNT_W'(1)) && out_load));
	assign pix_in.ready  = !s1_v || s1_move;
	assign accept        = pix_in.valid && pix_in.ready;

	//--------------------------------------------------------------------
	// Row/image end and character budget, decided at acceptance
	//--------------------------------------------------------------------
	always_comb begin
		col_inc   = CMP_W'(column_q) + CMP_W'(1);
		row_inc   = CMP_W'(row_q) + CMP_W'(1);
		row_end   = col_inc >= CMP_W'(width_q);
		img_end   = row_end && (row_inc >= CMP_W'(height_q));
		nl_needed = (mode_q == MODE_ASCII) && (budget_q < 0);

		dg_in[0] = to_digits(pix_in.red);
		dg_in[1] = to_digits(pix_in.green);
		dg_in[2] = to_digits(pix_in.blue);
		// each component costs its digits plus the space
		cost = 4'(dg_in[0].len) + 4'(dg_in[1].len) + 4'(dg_in[2].len) + 4'd3;

		budget_base = nl_needed ? BUDGET_NEWLINE : budget_q;
		if (row_end)
			budget_next = BUDGET_FULL;
		else if (mode_q == MODE_ASCII)
			budget_next = budget_base - 8'(cost);
		else
			budget_next = budget_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
			budget_q <= BUDGET_FULL;
		end else if (accept) begin
			budget_q <= budget_next;
			if (row_end) begin
				column_q <= '0;
				row_q    <= img_end ? '0 : row_inc[COORD_BITS-1:0];
			end else begin
				column_q <= col_inc[COORD_BITS-1:0];
			end
		end
	end

	//--------------------------------------------------------------------
	// Stage 1
	//--------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (accept) begin
			s1_v <= 1'b1;
		end else if (s1_move) begin
			s1_v <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			red_s1     <= pix_in.red;
			green_s1   <= pix_in.green;
			blue_s1    <= pix_in.blue;
			ascii_s1   <= (mode_q == MODE_ASCII);
			nl_s1      <= nl_needed;
			row_end_s1 <= row_end;
			img_end_s1 <= img_end;
		end
	end

	//--------------------------------------------------------------------
	// Expansion: pack the pixel's bytes, first byte lowest
	//--------------------------------------------------------------------
	always_comb begin
		dg_s1[0] = to_digits(red_s1);
		dg_s1[1] = to_digits(green_s1);
		dg_s1[2] = to_digits(blue_s1);
		stream   = '0;
		pos      = '0;
		if (ascii_s1) begin
			if (nl_s1) begin
				stream[7:0] = ASCII_LF;
				pos         = CNT_W'(1);
			end
			for (int i = 0; i < 3; i++) begin
				stream = stream | (STREAM_W'(digit_chunk(dg_s1[i])) << {pos, 3'b000});
				pos    = pos + CNT_W'(dg_s1[i].len) + CNT_W'(1);
			end
			if (row_end_s1) begin
				stream = stream | (STREAM_W'(ASCII_LF) << {pos, 3'b000});
				pos    = pos + CNT_W'(1);
			end
		end else begin
			stream[23:0] = {blue_s1, green_s1, red_s1};
			pos          = CNT_W'(3);
		end
	end

	//--------------------------------------------------------------------
	// Stage 2: shift out one byte per output load
	//--------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= '0;
		end else if (s1_move) begin
			cnt_s2 <= pos;
		end else if (out_load) begin
			cnt_s2 <= cnt_s2 - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			bytes_s2   <= stream;
			img_end_s2 <= img_end_s1;
		end else if (out_load) begin
			bytes_s2 <= bytes_s2 >> 8;
		end
	end

	//--------------------------------------------------------------------
	// Output register
	//--------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (byte_out.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q <= bytes_s2[7:0];
			out_last_q <= (cnt_s2 == CNT_W'(1));
			out_eoi_q  <= (cnt_s2 == CNT_W'(1)) && img_end_s2;
		end
	end

	assign byte_out.valid         = out_v_q;
	assign byte_out.out_byte      = out_byte_q;
	assign byte_out.last_of_pixel = out_last_q;
	assign byte_out.end_of_image  = out_eoi_q;

endmodule

[test/tb_ppm_pixel_body_encoder.sv]
// Self-checking testbench for ppm_pixel_body_encoder: directed table, then random phases.
// Depends on ppmenc_pkg, the three channel interfaces and the encoder RTL.
module tb_ppm_pixel_body_encoder;
	import ppmenc_pkg::*;

	// Run shape
	localparam int RANDOM_PIXELS = 166;
	localparam int SETTLE_CYCLES = 6;   // output lags a pixel transfer by stages s1 and s2
	localparam int NUM_PLAN      = 28;

	// Register indexes past the end of the register list; the block drops them
	localparam logic [CFG_IDX_W-1:0] IDX_PAST_LIST = 8'd3;
	localparam logic [CFG_IDX_W-1:0] IDX_TOP       = 8'hFF;

	typedef enum logic {
		STEP_PIXEL,
		STEP_WRITE
	} plan_kind_t;

	// One row of the directed table. n_exp > 0 means the bytes are typed in
	// (right-aligned in exp_bytes, first byte highest); 0 means use the predictor.
	typedef struct {
		plan_kind_t            kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic [PIX_W-1:0]      red;
		logic [PIX_W-1:0]      green;
		logic [PIX_W-1:0]      blue;
		int                    n_exp;
		logic [STREAM_W-1:0]   exp_bytes;
		logic                  exp_eoi;
	} plan_row_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_pixel;
		logic       end_of_image;
	} body_byte_t;

	logic clk;
	logic arst_n;

	ppmenc_cfg_if  cfg_ch ();
	ppmenc_pix_if  pix_ch ();
	ppmenc_byte_if byte_ch ();

	ppm_pixel_body_encoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_ch),
		.pix_in   (pix_ch),
		.byte_out (byte_ch)
	);

	// Predicted copy of the registers and the encoder state
	out_mode_t        mode_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [DIM_W-1:0] col_q;
	logic [DIM_W-1:0] row_q;
	int               budget_q;

	body_byte_t pixel_bytes [$];    // bytes of the pixel just encoded
	body_byte_t pending_bytes [$];  // bytes still owed by the block, oldest first

	int mismatches;
	int byte_count;
	int stall_left;
	bit quiet_phase;  // no idling on either side while set

	function automatic plan_row_t pix_row(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input int n, input logic [STREAM_W-1:0] bytes_in,
			input logic eoi);
		plan_row_t p;
		p = '{STEP_PIXEL, CFG_OUTPUT_MODE, '0, r, g, b, n, bytes_in, eoi};
		return p;
	endfunction

	function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		plan_row_t p;
		p = '{STEP_WRITE, idx, data, '0, '0, '0, 0, '0, 1'b0};
		return p;
	endfunction

	// Directed part. Typed rows: right after reset (1x1 binary image), and the
	// first ASCII pixels of a fresh 1x1 image, where the budget is still full.
	plan_row_t plan_table [NUM_PLAN] = '{
		pix_row(8'h00, 8'h00, 8'h00, 3, STREAM_W'(24'h000000), 1'b1),
		pix_row(8'hFF, 8'hFF, 8'hFF, 3, STREAM_W'(24'hFFFFFF), 1'b1),
		pix_row(8'h55, 8'hAA, 8'h0F, 0, '0, 1'b0),
		reg_row(CFG_OUTPUT_MODE, 16'(MODE_ASCII)),
		pix_row(8'd0, 8'd0, 8'd0, 7, STREAM_W'({"0 0 0 ", ASCII_LF}), 1'b1),
		pix_row(8'd255, 8'd255, 8'd255, 13, STREAM_W'({"255 255 255 ", ASCII_LF}), 1'b1),
		pix_row(8'd9, 8'd10, 8'd99, 0, '0, 1'b0),        // digit count boundaries
		pix_row(8'd100, 8'd199, 8'd200, 0, '0, 1'b0),
		reg_row(CFG_IMAGE_WIDTH, 16'd0),                 // zero width acts as one
		pix_row(8'd1, 8'd50, 8'd250, 0, '0, 1'b0),
		reg_row(CFG_IMAGE_HEIGHT, 16'd0),                // zero height acts as one
		pix_row(8'd8, 8'd90, 8'd128, 0, '0, 1'b0),
		reg_row(CFG_IMAGE_WIDTH, 16'd8),
		reg_row(CFG_IMAGE_HEIGHT, 16'd2),
		// eight widest pixels: the seventh sees a negative budget and gets a newline
		pix_row(8'd255, 8'd255, 8'd255, 0, '0, 1'b0),
		pix_row(8'd255, 8'd255, 8'd255, 0, '0, 1'b0),
		pix_row(8'd255, 8'd255, 8'd255, 0, '0, 1'b0),
		pix_row(8'd255, 8'd255, 8'd255, 0, '0, 1'b0),
		pix_row(8'd255, 8'd255, 8'd255, 0, '0, 1'b0),
		pix_row(8'd255, 8'd255, 8'd255, 0, '0, 1'b0),
		pix_row(8'd255, 8'd255, 8'd255, 0, '0, 1'b0),
		pix_row(8'd255, 8'd255, 8'd255, 0, '0, 1'b0),
		reg_row(IDX_PAST_LIST, 16'hFFFF),                // dropped
		reg_row(IDX_TOP, 16'h0001),                      // dropped
		reg_row(CFG_IMAGE_WIDTH, 16'hFFFF),
		reg_row(CFG_IMAGE_HEIGHT, 16'hFFFF),
		pix_row(8'd255, 8'd0, 8'd255, 0, '0, 1'b0),
		reg_row(CFG_OUTPUT_MODE, 16'(MODE_BINARY))
	};

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Idle length: mostly none, some short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Component values weighted toward the digit count edges
	function automatic logic [7:0] pick_level();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'($urandom_range(0, 9));
			3: return 8'($urandom_range(10, 99));
			4: return 8'($urandom_range(100, 255));
			5: begin
				case ($urandom_range(0, 5))
					0: return 8'd9;
					1: return 8'd10;
					2: return 8'd99;
					3: return 8'd100;
					4: return 8'd199;
					default: return 8'd200;
				endcase
			end
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Image dimension: extremes, tiny, wide enough for a mid-row newline, or anything
	function automatic logic [15:0] pick_dim();
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'd1;
			2: return 16'hFFFF;
			3: return 16'($urandom_range(0, 65535));
			4, 5: return 16'($urandom_range(7, 16));
			default: return 16'($urandom_range(2, 6));
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] byte %0d: %s", $realtime, byte_count, msg);
		mismatches++;
	endtask

	task automatic emit_byte(input logic [7:0] b);
		pixel_bytes.push_back('{b, 1'b0, 1'b0});
	endtask

	// Decimal text of one component plus its space; charges the line budget
	task automatic emit_decimal(input logic [7:0] v);
		int h;
		int t;
		int o;
		h = v / 100;
		t = (v % 100) / 10;
		o = v % 10;
		if (h != 0) begin
			emit_byte(ASCII_ZERO + 8'(h));
			emit_byte(ASCII_ZERO + 8'(t));
			emit_byte(ASCII_ZERO + 8'(o));
			budget_q -= 4;
		end else if (t != 0) begin
			emit_byte(ASCII_ZERO + 8'(t));
			emit_byte(ASCII_ZERO + 8'(o));
			budget_q -= 3;
		end else begin
			emit_byte(ASCII_ZERO + 8'(o));
			budget_q -= 2;
		end
		emit_byte(ASCII_SPACE);
	endtask

	// Predict the body bytes of one pixel into pixel_bytes and advance the counters
	task automatic encode_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		logic row_end;
		logic img_end;
		pixel_bytes.delete();
		// 17-bit compares: a zero bound is always reached, a passed bound too
		row_end = ({1'b0, col_q} + 17'd1) >= {1'b0, width_q};
		img_end = row_end && (({1'b0, row_q} + 17'd1) >= {1'b0, height_q});
		if (mode_q == MODE_BINARY) begin
			emit_byte(r);
			emit_byte(g);
			emit_byte(b);
		end else begin
			if (budget_q < 0) begin
				budget_q = BUDGET_NEWLINE;
				emit_byte(ASCII_LF);
			end
			emit_decimal(r);
			emit_decimal(g);
			emit_decimal(b);
			if (row_end) emit_byte(ASCII_LF);
		end
		pixel_bytes[$].last_of_pixel = 1'b1;
		pixel_bytes[$].end_of_image  = img_end;
		if (row_end) begin
			col_q    = '0;
			budget_q = BUDGET_FULL;
			row_q    = img_end ? '0 : row_q + 1'b1;
		end else begin
			col_q = col_q + 1'b1;
		end
	endtask

	// Offer one pixel and hold it until the transfer. Typed bytes, if given,
	// replace the prediction as the expectation; the predictor still advances.
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input int n_exp, input logic [STREAM_W-1:0] exp_bytes, input logic exp_eoi);
		int gap;
		pix_ch.valid <= 1'b1;
		pix_ch.red   <= r;
		pix_ch.green <= g;
		pix_ch.blue  <= b;
		do @(posedge clk); while (!pix_ch.ready);
		encode_pixel(r, g, b);
		if (n_exp == 0) begin
			foreach (pixel_bytes[k]) pending_bytes.push_back(pixel_bytes[k]);
		end else begin
			for (int k = 0; k < n_exp; k++)
				pending_bytes.push_back('{exp_bytes[(n_exp - 1 - k) * 8 +: 8],
					k == n_exp - 1, (k == n_exp - 1) && exp_eoi});
		end
		// valid only drops when a gap follows, so it never toggles within one step
		gap = quiet_phase ? 0 : idle_len();
		if (gap > 0) begin
			pix_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Let every owed byte come out, then let the pipeline settle
	task automatic settle_idle();
		pix_ch.valid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			CFG_OUTPUT_MODE:  mode_q   = out_mode_t'(data[0]);
			CFG_IMAGE_WIDTH:  width_q  = data;
			CFG_IMAGE_HEIGHT: height_q = data;
			default: ;  // past the list: no effect
		endcase
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Byte sink: check each transfer against the oldest owed byte, then pick
	// the next ready value. Pre-edge values are sampled, so no race with the DUT.
	always @(posedge clk) begin
		body_byte_t want;
		if (arst_n && byte_ch.valid && byte_ch.ready) begin
			if (pending_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h", byte_ch.out_byte));
			end else begin
				want = pending_bytes.pop_front();
				if (byte_ch.out_byte !== want.out_byte)
					report_mismatch($sformatf("out_byte %02h, want %02h",
						byte_ch.out_byte, want.out_byte));
				if (byte_ch.last_of_pixel !== want.last_of_pixel)
					report_mismatch($sformatf("last_of_pixel %b, want %b",
						byte_ch.last_of_pixel, want.last_of_pixel));
				if (byte_ch.end_of_image !== want.end_of_image)
					report_mismatch($sformatf("end_of_image %b, want %b",
						byte_ch.end_of_image, want.end_of_image));
			end
			byte_count++;
		end
		if (!arst_n) begin
			byte_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			byte_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			byte_ch.ready <= 1'b1;
			stall_left = quiet_phase ? 0 : idle_len();
		end
	end

	initial begin
		int sent;
		int phase_len;
		mismatches   = 0;
		byte_count   = 0;
		stall_left   = 0;
		quiet_phase  = 1'b0;
		mode_q       = MODE_BINARY;
		width_q      = 16'd1;
		height_q     = 16'd1;
		col_q        = '0;
		row_q        = '0;
		budget_q     = BUDGET_FULL;
		arst_n       = 1'b0;
		pix_ch.valid = 1'b0;
		pix_ch.red   = '0;
		pix_ch.green = '0;
		pix_ch.blue  = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data  = '0;
		byte_ch.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table; register writes only once the block has drained
		for (int k = 0; k < NUM_PLAN; k++) begin
			if (plan_table[k].kind == STEP_WRITE) begin
				settle_idle();
				write_reg(plan_table[k].idx, plan_table[k].data);
			end else begin
				send_pixel(plan_table[k].red, plan_table[k].green, plan_table[k].blue,
					plan_table[k].n_exp, plan_table[k].exp_bytes, plan_table[k].exp_eoi);
			end
		end

		// Random phases: new settings each phase, counters carried across, so a
		// lowered bound often lands behind the current position
		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			settle_idle();
			quiet_phase = ($urandom_range(0, 3) == 0);
			write_reg(CFG_OUTPUT_MODE, 16'($urandom_range(0, 1)));
			write_reg(CFG_IMAGE_WIDTH, pick_dim());
			write_reg(CFG_IMAGE_HEIGHT, pick_dim());
			if ($urandom_range(0, 3) == 0)
				write_reg(8'($urandom_range(IDX_PAST_LIST, IDX_TOP)), 16'($urandom_range(0, 65535)));
			phase_len = $urandom_range(8, 22);
			for (int k = 0; k < phase_len && sent < RANDOM_PIXELS; k++) begin
				send_pixel(pick_level(), pick_level(), pick_level(), 0, '0, 1'b0);
				sent++;
			end
		end

		settle_idle();
		quiet_phase = 1'b0;
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Watchdog, well past the slowest run: every byte behind a long stall
	initial begin
		#8000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

[ppm_pixel_body_encoder.f]
rtl/ppmenc_pkg.sv
rtl/ppmenc_pix_if.sv
rtl/ppmenc_byte_if.sv
rtl/ppmenc_cfg_if.sv
rtl/ppm_pixel_body_encoder.sv
test/tb_ppm_pixel_body_encoder.sv
